@@ hw/rtl/page_table_lru_frame_allocator_unit_macros.svh @@
// ----------------------------------------------------------------------------
// page table lru frame allocator assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_LRU_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_TABLE_LRU_FRAME_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define PTLFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ptlfa assertion failed");
// next-cycle implication, disabled during reset
`define PTLFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ptlfa assertion failed");
`else
`define PTLFA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PTLFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/ptlfa_pkg.sv @@
// ----------------------------------------------------------------------------
// ptlfa_pkg
// shared widths, defaults, sequencer states and control structs
// ----------------------------------------------------------------------------
package ptlfa_pkg;

	// fixed item field widths
	localparam int PTLFA_VA_W   = 12;
	localparam int PTLFA_PA_W   = 10;
	localparam int PTLFA_EVPG_W = 5;

	// parameter defaults
	localparam int PTLFA_PAGE_COUNT  = 32;
	localparam int PTLFA_FRAME_COUNT = 8;
	localparam int PTLFA_OFFSET_BITS = 7;
	localparam int PTLFA_STAMP_BITS  = 32;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_LOOKUP,
		ST_CHECK,
		ST_SCAN,
		ST_EVICT,
		ST_COMMIT
	} state_t;

	// sequencer to lru scan unit
	typedef struct packed {
		logic clear;
		logic sample;
	} scan_ctl_t;

endpackage

@@ hw/rtl/ptlfa_if.sv @@
// ----------------------------------------------------------------------------
// ptlfa channel interfaces
// request carries a virtual address, response carries the translation
// ----------------------------------------------------------------------------
interface ptlfa_req_if import ptlfa_pkg::*; ;
	logic                  valid;
	logic                  ready;
	logic [PTLFA_VA_W-1:0] virtual_address;

	modport source (output valid, output virtual_address, input ready);
	modport sink (input valid, input virtual_address, output ready);
endinterface

interface ptlfa_rsp_if import ptlfa_pkg::*; ;
	logic                    valid;
	logic                    ready;
	logic [PTLFA_PA_W-1:0]   physical_address;
	logic                    page_fault;
	logic                    evicted;
	logic [PTLFA_EVPG_W-1:0] evicted_page;

	modport source (output valid, output physical_address, output page_fault,
		output evicted, output evicted_page, input ready);
	modport sink (input valid, input physical_address, input page_fault,
		input evicted, input evicted_page, output ready);
endinterface

@@ hw/rtl/ptlfa_table_ram.sv @@
// ----------------------------------------------------------------------------
// ptlfa_table_ram
// page table memory, one write and one registered read port
// ----------------------------------------------------------------------------
module ptlfa_table_ram import ptlfa_pkg::*; #(
	parameter int DEPTH  = PTLFA_PAGE_COUNT,
	parameter int WIDTH  = 1 + 3 + PTLFA_STAMP_BITS,
	parameter int ADDR_W = $clog2(PTLFA_PAGE_COUNT)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] wa,
	input  logic [WIDTH-1:0]  wd,
	input  logic              re,
	input  logic [ADDR_W-1:0] ra,
	output logic [WIDTH-1:0]  rd
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[ra];
		end
	end

	assign rd = rd_q;

endmodule

@@ hw/rtl/ptlfa_lru_scan.sv @@
// ----------------------------------------------------------------------------
// ptlfa_lru_scan
// tracks the valid entry with the smallest stamp while the table streams by
// ----------------------------------------------------------------------------
module ptlfa_lru_scan import ptlfa_pkg::*; #(
	parameter int PAGE_W     = $clog2(PTLFA_PAGE_COUNT),
	parameter int FRAME_W    = $clog2(PTLFA_FRAME_COUNT),
	parameter int STAMP_BITS = PTLFA_STAMP_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scan_ctl_t             ctl,
	input  logic                  ent_valid,
	input  logic [FRAME_W-1:0]    ent_frame,
	input  logic [STAMP_BITS-1:0] ent_stamp,
	input  logic [PAGE_W-1:0]     ent_idx,
	output logic                  found,
	output logic [PAGE_W-1:0]     best_idx,
	output logic [FRAME_W-1:0]    best_frame
);

	logic                  found_q;
	logic [STAMP_BITS-1:0] best_stamp_q;
	logic [PAGE_W-1:0]     best_idx_q;
	logic [FRAME_W-1:0]    best_frame_q;
	logic                  take;

	// strict less-than keeps the lowest index on a tie
	assign take = ctl.sample && ent_valid && (!found_q || (ent_stamp < best_stamp_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !ctl.clear) begin
			best_stamp_q <= ent_stamp;
			best_idx_q   <= ent_idx;
			best_frame_q <= ent_frame;
		end
	end

	assign found      = found_q;
	assign best_idx   = best_idx_q;
	assign best_frame = best_frame_q;

endmodule

@@ hw/rtl/page_table_lru_frame_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// page_table_lru_frame_allocator_unit
// demand paging translator with lru frame replacement
// ----------------------------------------------------------------------------
// usage
//   req channel: one virtual address per item, taken while the sequencer is
//   idle. rsp channel: physical address, page fault flag, evicted flag and
//   evicted page, one item per request, in order.
//   the page table (valid, frame, stamp per page) sits in one synchronous
//   memory with a registered read, so every item is a read, a decision and a
//   write-back through its read port and its write port.
//   hit or fault with a free frame: lookup, check and commit, then idle again.
//   fault with eviction: check, then a walk over every table entry, one
//   memory read per cycle, then evict and commit.
//   a page count that is neither a power of two nor covering the whole page
//   field adds a reduction state with one restoring step per page-field bit.
//   after reset the table is swept once to clear its valid bits, entry by
//   entry, while req.ready stays low.
//   the result sits in an output register; a stalled receiver holds it there
//   and the next item may still be accepted and worked up to write-back,
//   where it waits until the output register frees up.
// ----------------------------------------------------------------------------
`include "page_table_lru_frame_allocator_unit_macros.svh"

module page_table_lru_frame_allocator_unit import ptlfa_pkg::*; #(
	parameter int PAGE_COUNT  = PTLFA_PAGE_COUNT,
	parameter int FRAME_COUNT = PTLFA_FRAME_COUNT,
	parameter int OFFSET_BITS = PTLFA_OFFSET_BITS,
	parameter int STAMP_BITS  = PTLFA_STAMP_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	ptlfa_req_if.sink    req,
	ptlfa_rsp_if.source  rsp
);

	// derived widths
	localparam int PAGE_W  = $clog2(PAGE_COUNT);
	localparam int CNT_W   = $clog2(PAGE_COUNT + 1);
	localparam int FRAME_W = $clog2(FRAME_COUNT);
	localparam int NF_W    = $clog2(FRAME_COUNT + 1);
	localparam int OFF_W   = (OFFSET_BITS < PTLFA_VA_W) ? OFFSET_BITS : PTLFA_VA_W;
	localparam int HI_W    = (OFFSET_BITS < PTLFA_VA_W) ? (PTLFA_VA_W - OFFSET_BITS) : 1;
	localparam int K_W     = (HI_W > 1) ? $clog2(HI_W) : 1;
	localparam int RW      = HI_W + PAGE_W;
	localparam int MEM_W   = 1 + FRAME_W + STAMP_BITS;
	localparam int PA_FW   = ((FRAME_W + OFFSET_BITS + 1) > PTLFA_PA_W) ?
		(FRAME_W + OFFSET_BITS + 1) : PTLFA_PA_W;
	// page field wider than the table and not a power of two: reduce it
	localparam bit NEED_RED = ((PAGE_COUNT & (PAGE_COUNT - 1)) != 0) &&
		(PAGE_COUNT < (2 ** HI_W));

	state_t state_q, state_d;

	logic [CNT_W-1:0]      cnt_q;
	logic [HI_W-1:0]       red_q;
	logic [K_W-1:0]        red_k_q;
	logic [OFF_W-1:0]      off_q;
	logic [PAGE_W-1:0]     page_q;
	logic [FRAME_W-1:0]    frame_q;
	logic                  fault_q;
	logic                  evict_q;
	logic [PAGE_W-1:0]     victim_q;
	logic [NF_W-1:0]       next_free_q;
	logic [STAMP_BITS-1:0] counter_q;
	logic [PAGE_W-1:0]     scan_idx_s1;

	// output register
	logic                    rsp_valid_q;
	logic [PTLFA_PA_W-1:0]   pa_q;
	logic                    pf_q;
	logic                    ev_q;
	logic [PTLFA_EVPG_W-1:0] evpg_q;

	// memory ports
	logic              mem_we;
	logic [PAGE_W-1:0] mem_wa;
	logic [MEM_W-1:0]  mem_wd;
	logic              mem_re;
	logic [PAGE_W-1:0] mem_ra;
	logic [MEM_W-1:0]  mem_rd;

	logic                  rd_valid;
	logic [FRAME_W-1:0]    rd_frame;
	logic [STAMP_BITS-1:0] rd_stamp;

	scan_ctl_t          scan_ctl;
	logic               scan_found;
	logic [PAGE_W-1:0]  scan_idx;
	logic [FRAME_W-1:0] scan_frame;

	logic              accept;
	logic              out_free;
	logic              free_avail;
	logic [PAGE_W-1:0] page_w;
	logic [RW-1:0]     red_sub;
	logic [RW-1:0]     red_diff;
	logic              red_ge;
	logic [PA_FW-1:0]  pa_full;

	assign accept     = req.valid && req.ready;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign free_avail = next_free_q < NF_W'(FRAME_COUNT);

	// entry word: valid, frame, stamp
	assign rd_valid = mem_rd[MEM_W-1];
	assign rd_frame = mem_rd[STAMP_BITS +: FRAME_W];
	assign rd_stamp = mem_rd[STAMP_BITS-1:0];

	// page number; truncation is the mask for power-of-two tables
	assign page_w = PAGE_W'(red_q);

	// one restoring step of the page modulo per cycle
	assign red_sub  = RW'(PAGE_COUNT) << red_k_q;
	assign red_ge   = RW'(red_q) >= red_sub;
	assign red_diff = RW'(red_q) - red_sub;

	// frame bits never overlap the offset, so add is a concatenation
	assign pa_full = (PA_FW'(frame_q) << OFFSET_BITS) + PA_FW'(off_q);

	ptlfa_table_ram #(
		.DEPTH  (PAGE_COUNT),
		.WIDTH  (MEM_W),
		.ADDR_W (PAGE_W)
	) u_ram (
		.clk (clk),
		.we  (mem_we),
		.wa  (mem_wa),
		.wd  (mem_wd),
		.re  (mem_re),
		.ra  (mem_ra),
		.rd  (mem_rd)
	);

	ptlfa_lru_scan #(
		.PAGE_W     (PAGE_W),
		.FRAME_W    (FRAME_W),
		.STAMP_BITS (STAMP_BITS)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.ent_valid  (rd_valid),
		.ent_frame  (rd_frame),
		.ent_stamp  (rd_stamp),
		.ent_idx    (scan_idx_s1),
		.found      (scan_found),
		.best_idx   (scan_idx),
		.best_frame (scan_frame)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory / scan controls
	// accesses to the same entry never overlap: every write lands before the
	// next read of the table is issued
	always_comb begin
		state_d  = state_q;
		mem_we   = 1'b0;
		mem_wa   = page_q;
		mem_wd   = '0;
		mem_re   = 1'b0;
		mem_ra   = page_w;
		scan_ctl = '0;
		unique case (state_q)
			ST_CLEAR: begin
				// sweep valid bits low after reset
				mem_we = 1'b1;
				mem_wa = cnt_q[PAGE_W-1:0];
				mem_wd = '0;
				if (cnt_q == CNT_W'(PAGE_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = NEED_RED ? ST_REDUCE : ST_LOOKUP;
				end
			end
			ST_REDUCE: begin
				if (red_k_q == '0) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				mem_re  = 1'b1;
				mem_ra  = page_w;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (rd_valid || free_avail) begin
					state_d = ST_COMMIT;
				end else begin
					scan_ctl.clear = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// read entry cnt, fold in the entry read last cycle
				mem_re          = cnt_q < CNT_W'(PAGE_COUNT);
				mem_ra          = cnt_q[PAGE_W-1:0];
				scan_ctl.sample = cnt_q != '0;
				if (cnt_q == CNT_W'(PAGE_COUNT)) begin
					state_d = ST_EVICT;
				end
			end
			ST_EVICT: begin
				// invalidate the lru page, its frame moves to the faulting page
				mem_we  = scan_found;
				mem_wa  = scan_idx;
				mem_wd  = {1'b0, scan_frame, STAMP_BITS'(0)};
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				// write back the accessed page with a fresh stamp
				if (out_free) begin
					mem_we  = 1'b1;
					mem_wa  = page_q;
					mem_wd  = {1'b1, frame_q, counter_q};
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			next_free_q <= NF_W'(1);
			counter_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == ST_CHECK) begin
				cnt_q <= '0;
			end
			if (state_q == ST_CHECK && !rd_valid && free_avail) begin
				next_free_q <= next_free_q + NF_W'(1);
			end
			if (state_q == ST_COMMIT && out_free) begin
				counter_q   <= counter_q + STAMP_BITS'(1);
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			red_q   <= HI_W'(req.virtual_address >> OFFSET_BITS);
			off_q   <= OFF_W'(req.virtual_address);
			red_k_q <= K_W'(HI_W - 1);
		end else if (state_q == ST_REDUCE) begin
			if (red_ge) begin
				red_q <= HI_W'(red_diff);
			end
			red_k_q <= red_k_q - K_W'(1);
		end
		if (state_q == ST_LOOKUP) begin
			page_q <= page_w;
		end
		if (state_q == ST_SCAN) begin
			scan_idx_s1 <= cnt_q[PAGE_W-1:0];
		end
		if (state_q == ST_CHECK) begin
			fault_q  <= !rd_valid;
			evict_q  <= 1'b0;
			victim_q <= '0;
			frame_q  <= rd_valid ? rd_frame : FRAME_W'(next_free_q);
		end
		if (state_q == ST_EVICT) begin
			// no valid page at all would leave frame 0 and no eviction
			evict_q  <= scan_found;
			victim_q <= scan_found ? scan_idx : '0;
			frame_q  <= scan_found ? scan_frame : '0;
		end
		if (state_q == ST_COMMIT && out_free) begin
			pa_q   <= pa_full[PTLFA_PA_W-1:0];
			pf_q   <= fault_q;
			ev_q   <= evict_q;
			evpg_q <= PTLFA_EVPG_W'(victim_q);
		end
	end

	assign req.ready            = state_q == ST_IDLE;
	assign rsp.valid            = rsp_valid_q;
	assign rsp.physical_address = pa_q;
	assign rsp.page_fault       = pf_q;
	assign rsp.evicted          = ev_q;
	assign rsp.evicted_page     = evpg_q;

	// an accepted item always leaves idle
	`PTLFA_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != ST_IDLE)
	// eviction only once every free frame (1 up to FRAME_COUNT-1) has been handed out
	`PTLFA_ASSERT_IMPL(a_evict_full, clk, arst_n, (state_q == ST_EVICT) && scan_found,
		next_free_q == NF_W'(FRAME_COUNT))
	// the faulting page is never its own victim
	`PTLFA_ASSERT_IMPL(a_victim_differs, clk, arst_n, (state_q == ST_COMMIT) && evict_q,
		victim_q != page_q)

endmodule

@@ tb/page_table_lru_frame_allocator_unit_checker.sv @@
// ----------------------------------------------------------------------------
// page table lru frame allocator checker
// watches both channels, predicts each translation and compares it in order
// ----------------------------------------------------------------------------
module page_table_lru_frame_allocator_unit_checker import ptlfa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	ptlfa_req_if  req,
	ptlfa_rsp_if  rsp,
	output int    fail_count,
	output int    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGE_W  = PTLFA_VA_W - PTLFA_OFFSET_BITS;
	localparam int FRAME_W = $clog2(PTLFA_FRAME_COUNT);

	typedef struct packed {
		logic [PTLFA_PA_W-1:0]   physical_address;
		logic                    page_fault;
		logic                    evicted;
		logic [PTLFA_EVPG_W-1:0] evicted_page;
	} xlat_t;

	// shadow page table
	logic                        tbl_valid [PTLFA_PAGE_COUNT];
	logic [FRAME_W-1:0]          tbl_frame [PTLFA_PAGE_COUNT];
	logic [PTLFA_STAMP_BITS-1:0] tbl_stamp [PTLFA_PAGE_COUNT];
	logic [FRAME_W:0]            free_frame;
	logic [PTLFA_STAMP_BITS-1:0] stamp_counter;

	xlat_t expected_xlat [$];
	int    fails = 0;

	function automatic xlat_t translate_access(logic [PTLFA_VA_W-1:0] va);
		logic [PAGE_W-1:0]              page;
		logic [PTLFA_OFFSET_BITS-1:0]   offset;
		logic [FRAME_W-1:0]             frame;
		logic                           found;
		logic [PTLFA_STAMP_BITS-1:0]    oldest;
		int                             victim;
		xlat_t                          res;
		page   = PAGE_W'(va[PTLFA_VA_W-1:PTLFA_OFFSET_BITS] % PTLFA_PAGE_COUNT);
		offset = va[PTLFA_OFFSET_BITS-1:0];
		res    = '0;
		if (tbl_valid[page]) begin
			frame = tbl_frame[page];
		end else begin
			res.page_fault = 1'b1;
			if (free_frame < PTLFA_FRAME_COUNT) begin
				frame      = free_frame[FRAME_W-1:0];
				free_frame = free_frame + (FRAME_W+1)'(1);
			end else begin
				// lowest numbered page wins a stamp tie
				found  = 1'b0;
				oldest = '0;
				victim = 0;
				for (int i = 0; i < PTLFA_PAGE_COUNT; i++) begin
					if (tbl_valid[i] && (!found || tbl_stamp[i] < oldest)) begin
						found  = 1'b1;
						oldest = tbl_stamp[i];
						victim = i;
					end
				end
				if (found) begin
					frame                = tbl_frame[victim];
					tbl_valid[victim]    = 1'b0;
					res.evicted          = 1'b1;
					res.evicted_page     = victim[PTLFA_EVPG_W-1:0];
				end else begin
					frame = '0;
				end
			end
			tbl_frame[page] = frame;
			tbl_valid[page] = 1'b1;
		end
		tbl_stamp[page]      = stamp_counter;
		stamp_counter        = stamp_counter + PTLFA_STAMP_BITS'(1);
		res.physical_address = PTLFA_PA_W'({frame, offset});
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		xlat_t exp_x;
		if (!arst_n) begin
			for (int i = 0; i < PTLFA_PAGE_COUNT; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_frame[i] = '0;
				tbl_stamp[i] = '0;
			end
			free_frame    = (FRAME_W+1)'(1);
			stamp_counter = '0;
			expected_xlat.delete();
			outstanding  <= 0;
		end else begin
			// result side first: a result never belongs to an item taken at the same edge
			if (rsp.valid && rsp.ready) begin
				if (expected_xlat.size() == 0) begin
					$error("result item with no translation pending: pa %0d",
						rsp.physical_address);
					fails++;
				end else begin
					exp_x = expected_xlat.pop_front();
					if (rsp.physical_address !== exp_x.physical_address) begin
						$error("physical_address: expected %0d, got %0d",
							exp_x.physical_address, rsp.physical_address);
						fails++;
					end
					if (rsp.page_fault !== exp_x.page_fault) begin
						$error("page_fault: expected %0d, got %0d",
							exp_x.page_fault, rsp.page_fault);
						fails++;
					end
					if (rsp.evicted !== exp_x.evicted) begin
						$error("evicted: expected %0d, got %0d",
							exp_x.evicted, rsp.evicted);
						fails++;
					end
					if (rsp.evicted_page !== exp_x.evicted_page) begin
						$error("evicted_page: expected %0d, got %0d",
							exp_x.evicted_page, rsp.evicted_page);
						fails++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_xlat.push_back(translate_access(req.virtual_address));
			outstanding <= expected_xlat.size();
		end
		fail_count <= fails;
	end

endmodule

@@ tb/page_table_lru_frame_allocator_unit_tb.sv @@
// ----------------------------------------------------------------------------
// page table lru frame allocator testbench
// directed and random virtual addresses with random stalls on both channels,
// checked in order against a shadow page table in the checker
// ----------------------------------------------------------------------------
module page_table_lru_frame_allocator_unit_tb import ptlfa_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_ITEMS = 1130;
	localparam int          HOLD_CYCLES  = 400;     // long receiver hold-off
	localparam int          DRAIN_CYCLES = 60;      // more than one eviction walk
	localparam int unsigned CYCLE_LIMIT  = 900_000;
	localparam int          PAGE_W       = PTLFA_VA_W - PTLFA_OFFSET_BITS;

	logic clk = 1'b0;
	logic arst_n;

	ptlfa_req_if req_ch ();
	ptlfa_rsp_if rsp_ch ();

	int          fail_count;
	int          outstanding;
	int unsigned cycle_count = 0;
	logic        long_hold = 1'b0;    // set by stimulus, cleared by the receiver

	// directed items: page and offset extremes, fill every frame, hits that
	// refresh a stamp, evictions, and refaults of pages that lost their frame
	logic [PTLFA_VA_W-1:0] directed_addrs [22] = '{
		12'h000, 12'hFFF, 12'h07F, 12'hF80, 12'h080, 12'h100, 12'h180, 12'h200,
		12'h280, 12'h000, 12'h555, 12'hAAA, 12'h300, 12'h380, 12'h400, 12'h480,
		12'hFFF, 12'h07F, 12'h080, 12'h555, 12'h600, 12'hF80
	};

	page_table_lru_frame_allocator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	page_table_lru_frame_allocator_unit_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// offer one item and hold it until taken, then maybe leave a gap
	task automatic send_item(input logic [PTLFA_VA_W-1:0] va, input bit allow_gap);
		int gap;
		req_ch.valid           <= 1'b1;
		req_ch.virtual_address <= va;
		do @(posedge clk); while (!req_ch.ready);
		// item taken at this edge
		gap = 0;
		if (allow_gap) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = 0;
				9:             gap = $urandom_range(10, 60);
				default:       gap = $urandom_range(1, 4);
			endcase
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every pending translation to come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// receiver: runs of ready and stalls, most short and a few long,
	// plus one long hold-off on request
	initial begin
		int run_left;
		int stall_left;
		run_left   = 0;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
				for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
				long_hold = 1'b0;
			end else if (run_left > 0) begin
				rsp_ch.ready <= 1'b1;
				run_left--;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				// pick the next run and stall; a long ready run gives stretches with no idling
				run_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 30);
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
					: $urandom_range(0, 3);
			end
		end
	end

	// stimulus and verdict
	initial begin
		logic [PAGE_W-1:0]            page;
		logic [PAGE_W-1:0]            hot_base;
		logic [PTLFA_OFFSET_BITS-1:0] offset;
		logic [PTLFA_VA_W-1:0]        va;
		arst_n                 <= 1'b0;
		req_ch.valid           <= 1'b0;
		req_ch.virtual_address <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back; the table clear after reset holds it off
		foreach (directed_addrs[i])
			send_item(directed_addrs[i], 1'b0);
		drain_results();

		// random part: mostly a drifting hot set of ten pages, a bit larger than
		// the seven usable frames, so hits, refreshes and evictions all occur
		hot_base = PAGE_W'($urandom_range(0, PTLFA_PAGE_COUNT - 1));
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				hot_base = PAGE_W'($urandom_range(0, PTLFA_PAGE_COUNT - 1));
			if ($urandom_range(0, 3) == 0)
				page = PAGE_W'($urandom_range(0, PTLFA_PAGE_COUNT - 1));
			else
				page = hot_base + PAGE_W'($urandom_range(0, 9));
			offset = PTLFA_OFFSET_BITS'($urandom_range(0, 127));
			va     = {page, offset};
			if (n == 400) begin
				// long receiver hold-off while items keep coming, so the block backs up
				long_hold = 1'b1;
				for (int k = 0; k < 30; k++)
					send_item(PTLFA_VA_W'($urandom_range(0, 4095)), 1'b0);
			end
			if (n == 700)
				drain_results();
			send_item(va, 1'b1);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
